@@ sv/snl_pkg.sv @@
// shared constants, types and a helper function for the sorted nearest lookup table
package snl_pkg;

	localparam int TABLE_DEPTH  = 64;
	localparam int DATA_WIDTH   = 32;
	localparam int ADDR_WIDTH   = $clog2(TABLE_DEPTH);
	localparam int CNT_WIDTH    = ADDR_WIDTH + 1;
	localparam int ENTRY_WIDTH  = 2 * DATA_WIDTH;
	localparam int OP_WIDTH     = 2;
	localparam int STATUS_WIDTH = 2;

	typedef enum logic [OP_WIDTH-1:0] {
		OP_INSERT  = 2'd0,
		OP_LOOKUP  = 2'd1,
		OP_REVERSE = 2'd2
	} op_t;

	typedef enum logic [STATUS_WIDTH-1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_DUP   = 2'd2,
		STAT_FULL  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_WRNEW,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [OP_WIDTH-1:0]          op;
		logic signed [DATA_WIDTH-1:0] key;
		logic signed [DATA_WIDTH-1:0] value;
	} req_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] answer;
		status_t                      status;
	} res_t;

	typedef struct packed {
		logic                   rd_en;
		logic [ADDR_WIDTH-1:0]  rd_addr;
		logic                   wr_en;
		logic [ADDR_WIDTH-1:0]  wr_addr;
		logic [ENTRY_WIDTH-1:0] wr_data;
	} mem_cmd_t;

	function automatic logic [DATA_WIDTH:0] abs_diff(
		input logic signed [DATA_WIDTH-1:0] a,
		input logic signed [DATA_WIDTH-1:0] b
	);
		logic signed [DATA_WIDTH:0] d;
		d = $signed({a[DATA_WIDTH-1], a}) - $signed({b[DATA_WIDTH-1], b});
		return d[DATA_WIDTH] ? $unsigned(-d) : $unsigned(d);
	endfunction

endpackage

@@ sv/snl_ram.sv @@
// simple dual-port synchronous ram with registered read data
module snl_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ sv/snl_engine.sv @@
// sequencer that scans, shifts and searches the sorted table held in ram
module snl_engine (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  snl_pkg::req_t               req,
	output logic                        res_valid,
	input  logic                        res_ready,
	output snl_pkg::res_t               res,
	output snl_pkg::mem_cmd_t           mem,
	input  logic [snl_pkg::ENTRY_WIDTH-1:0] rd_data
);

	snl_pkg::state_t state_q, state_d;

	logic [snl_pkg::OP_WIDTH-1:0]          op_q;
	logic signed [snl_pkg::DATA_WIDTH-1:0] key_q;
	logic signed [snl_pkg::DATA_WIDTH-1:0] val_q;
	logic [snl_pkg::CNT_WIDTH-1:0]         cnt_q;
	logic [snl_pkg::CNT_WIDTH-1:0]         ra_q;
	logic [snl_pkg::CNT_WIDTH-1:0]         pos_q;
	logic                                  v_s1;
	logic [snl_pkg::ADDR_WIDTH-1:0]        idx_s1;
	logic signed [snl_pkg::DATA_WIDTH-1:0] prev_key_q;
	logic signed [snl_pkg::DATA_WIDTH-1:0] prev_val_q;
	logic [snl_pkg::DATA_WIDTH:0]          best_d_q;
	logic signed [snl_pkg::DATA_WIDTH-1:0] best_key_q;
	logic signed [snl_pkg::DATA_WIDTH-1:0] ans_q;
	snl_pkg::status_t                      stat_q;

	logic signed [snl_pkg::DATA_WIDTH-1:0] rd_key;
	logic signed [snl_pkg::DATA_WIDTH-1:0] rd_val;
	logic [snl_pkg::DATA_WIDTH:0]          d_near;
	logic [snl_pkg::DATA_WIDTH:0]          d_far;
	logic [snl_pkg::DATA_WIDTH:0]          rev_d;
	logic                                  ge;
	logic                                  last;
	logic                                  rev_take;
	logic                                  scan_hit;
	logic                                  scan_end;
	logic                                  dup;
	logic                                  full;
	logic                                  empty;
	logic                                  accept;
	logic                                  new_wr;

	// datapath decisions
	always_comb begin
		rd_key   = rd_data[snl_pkg::DATA_WIDTH-1:0];
		rd_val   = rd_data[snl_pkg::ENTRY_WIDTH-1:snl_pkg::DATA_WIDTH];
		ge       = rd_key >= key_q;
		last     = {1'b0, idx_s1} == (cnt_q - snl_pkg::CNT_WIDTH'(1));
		d_near   = snl_pkg::abs_diff(rd_key, key_q);
		d_far    = snl_pkg::abs_diff(key_q, prev_key_q);
		rev_d    = snl_pkg::abs_diff(val_q, rd_val);
		rev_take = (idx_s1 == '0) || (rev_d < best_d_q);
		scan_hit = v_s1 && (op_q != snl_pkg::OP_REVERSE) && ge;
		scan_end = v_s1 && (scan_hit || last);
		dup      = scan_hit && (rd_key == key_q);
		full     = cnt_q == snl_pkg::CNT_WIDTH'(snl_pkg::TABLE_DEPTH);
		empty    = cnt_q == '0;
		accept   = req_valid && req_ready;
		new_wr   = (state_q == snl_pkg::S_WRNEW) && !v_s1;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			snl_pkg::S_IDLE: begin
				if (req_valid) begin
					unique case (req.op)
						snl_pkg::OP_INSERT:  state_d = empty ? snl_pkg::S_WRNEW : snl_pkg::S_SCAN;
						snl_pkg::OP_LOOKUP,
						snl_pkg::OP_REVERSE: state_d = empty ? snl_pkg::S_DONE : snl_pkg::S_SCAN;
						default:             state_d = snl_pkg::S_DONE;
					endcase
				end
			end
			snl_pkg::S_SCAN: begin
				if (scan_end) begin
					if (op_q != snl_pkg::OP_INSERT || dup || full) begin
						state_d = snl_pkg::S_DONE;
					end else if (scan_hit) begin
						state_d = snl_pkg::S_SHIFT;
					end else begin
						state_d = snl_pkg::S_WRNEW;
					end
				end
			end
			snl_pkg::S_SHIFT: begin
				if (ra_q == pos_q) begin
					state_d = snl_pkg::S_WRNEW;
				end
			end
			snl_pkg::S_WRNEW: begin
				if (!v_s1) begin
					state_d = snl_pkg::S_DONE;
				end
			end
			snl_pkg::S_DONE: begin
				if (res_ready) begin
					state_d = snl_pkg::S_IDLE;
				end
			end
			default: state_d = snl_pkg::S_IDLE;
		endcase
	end

	// outputs and memory commands
	always_comb begin
		req_ready   = state_q == snl_pkg::S_IDLE;
		res_valid   = state_q == snl_pkg::S_DONE;
		res.answer  = ans_q;
		res.status  = stat_q;
		mem.rd_addr = ra_q[snl_pkg::ADDR_WIDTH-1:0];
		mem.rd_en   = ((state_q == snl_pkg::S_SCAN) && (ra_q < cnt_q) && !scan_end)
			|| (state_q == snl_pkg::S_SHIFT);
		mem.wr_en   = 1'b0;
		mem.wr_addr = idx_s1 + snl_pkg::ADDR_WIDTH'(1);
		mem.wr_data = rd_data;
		if (v_s1 && (state_q == snl_pkg::S_SHIFT || state_q == snl_pkg::S_WRNEW)) begin
			mem.wr_en = 1'b1;
		end else if (new_wr) begin
			mem.wr_en   = 1'b1;
			mem.wr_addr = pos_q[snl_pkg::ADDR_WIDTH-1:0];
			mem.wr_data = {val_q, key_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= snl_pkg::S_IDLE;
			cnt_q   <= '0;
			v_s1    <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= mem.rd_en;
			if (new_wr) begin
				cnt_q <= cnt_q + snl_pkg::CNT_WIDTH'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem.rd_en) begin
			idx_s1 <= mem.rd_addr;
		end
		if (accept) begin
			op_q  <= req.op;
			key_q <= req.key;
			val_q <= req.value;
			ra_q  <= '0;
			pos_q <= '0;
			ans_q <= '0;
			stat_q <= ((req.op == snl_pkg::OP_LOOKUP || req.op == snl_pkg::OP_REVERSE) && empty)
				? snl_pkg::STAT_EMPTY : snl_pkg::STAT_OK;
		end
		if (state_q == snl_pkg::S_SCAN) begin
			if (mem.rd_en) begin
				ra_q <= ra_q + snl_pkg::CNT_WIDTH'(1);
			end
			if (v_s1) begin
				prev_key_q <= rd_key;
				prev_val_q <= rd_val;
				if (rev_take) begin
					best_d_q   <= rev_d;
					best_key_q <= rd_key;
				end
			end
			if (scan_end) begin
				unique case (op_q)
					snl_pkg::OP_INSERT: begin
						pos_q <= scan_hit ? {1'b0, idx_s1} : cnt_q;
						ra_q  <= cnt_q - snl_pkg::CNT_WIDTH'(1);
						if (dup) begin
							stat_q <= snl_pkg::STAT_DUP;
						end else if (full) begin
							stat_q <= snl_pkg::STAT_FULL;
						end
					end
					snl_pkg::OP_LOOKUP: begin
						if (!scan_hit || idx_s1 == '0 || d_near < d_far) begin
							ans_q <= rd_val;
						end else begin
							ans_q <= prev_val_q;
						end
					end
					default: begin
						ans_q <= rev_take ? rd_key : best_key_q;
					end
				endcase
			end
		end
		if (state_q == snl_pkg::S_SHIFT && ra_q != pos_q) begin
			ra_q <= ra_q - snl_pkg::CNT_WIDTH'(1);
		end
	end

endmodule

@@ sv/sorted_nearest_lookup_table_top.sv @@
// top level of the sorted nearest lookup table with stream ports and result register
// throughput: one request at a time; the next is taken as soon as the result is registered
// the pace is set by the single ram read port, one stored entry per cycle
// reset clears the entry count and the handshake state; the ram contents are not cleared
// and need no clearing pass, so requests are taken right after reset
module sorted_nearest_lookup_table_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // key [31:0], value [63:32]
	input  logic [1:0]  s_tuser,  // op [1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // answer [31:0]
	output logic [1:0]  m_tuser   // status [1:0]
);

	snl_pkg::req_t     req;
	snl_pkg::res_t     res;
	snl_pkg::mem_cmd_t mem;
	logic [snl_pkg::ENTRY_WIDTH-1:0] rd_data;
	logic res_valid;
	logic res_ready;
	logic m_tvalid_q;
	logic [31:0] m_tdata_q;
	logic [1:0]  m_tuser_q;

	always_comb begin
		req.op    = s_tuser;
		req.key   = s_tdata[31:0];
		req.value = s_tdata[63:32];
	end

	snl_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_tvalid),
		.req_ready (s_tready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem       (mem),
		.rd_data   (rd_data)
	);

	snl_ram #(
		.DEPTH (snl_pkg::TABLE_DEPTH),
		.WIDTH (snl_pkg::ENTRY_WIDTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (mem.wr_en),
		.wr_addr (mem.wr_addr),
		.wr_data (mem.wr_data),
		.rd_en   (mem.rd_en),
		.rd_addr (mem.rd_addr),
		.rd_data (rd_data)
	);

	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			m_tdata_q <= res.answer;
			m_tuser_q <= res.status;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule
